// ===== rtl/core/itp_pkg.sv =====
// itp_pkg: shared types, constants and character helpers for the integer text parser
// used by integer_text_parser and its port checker; no dependencies
`default_nettype none

package itp_pkg;

  localparam int unsigned ValueBits = 32;
  localparam int unsigned IndexBits = 16;
  localparam int unsigned BaseBits  = 6;
  localparam int unsigned CfgIdxBits  = 4;
  localparam int unsigned CfgDataBits = 8;

  // configuration register indexes
  localparam logic [CfgIdxBits-1:0] CfgNumberBase   = CfgIdxBits'(0);
  localparam logic [CfgIdxBits-1:0] CfgSignedResult = CfgIdxBits'(1);

  // digit value returned for a character that is no digit
  localparam logic [BaseBits-1:0] NoDigit = BaseBits'(36);

  typedef struct packed {
    logic [7:0] char_code;
    logic       last;
  } in_word_t;

  typedef struct packed {
    logic [ValueBits-1:0] value;
    logic [IndexBits-1:0] end_index;
    logic                 converted;
    logic                 range_error;
  } out_word_t;

  // 0..35 for a digit character in any case, NoDigit otherwise
  function automatic logic [BaseBits-1:0] digit_of(input logic [7:0] c);
    logic [BaseBits-1:0] d;
    d = NoDigit;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = BaseBits'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h7a) begin
      d = BaseBits'(c - 8'h61 + 8'd10);
    end else if (c >= 8'h41 && c <= 8'h5a) begin
      d = BaseBits'(c - 8'h41 + 8'd10);
    end
    return d;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0d);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/integer_text_parser.sv =====
// integer_text_parser: streaming strtol/strtoul style parser, one character per word
// depends on itp_pkg for the word structs, config indexes and character helpers
`default_nettype none

// datapath: input register, parse step and overflow check, then result register
// throughput: one character per cycle, unless a last character waits on a full and
//   undrained result register; the parse step is one 32x6 multiply-add
// reset: asynchronous, active low; clears parser state, both valid flags and sets
//   number_base to 0 (auto) and signed_result to 1
module integer_text_parser (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  // character words
  input  wire                            in_valid_i,
  output logic                           in_ready_o,
  input  itp_pkg::in_word_t              in_word_i,
  // result words
  output logic                           out_valid_o,
  input  wire                            out_ready_i,
  output itp_pkg::out_word_t             out_word_o,
  // configuration writes
  input  wire                            cfg_valid_i,
  output logic                           cfg_ready_o,
  input  wire [itp_pkg::CfgIdxBits-1:0]  cfg_index_i,
  input  wire [itp_pkg::CfgDataBits-1:0] cfg_data_i
);
  import itp_pkg::*;

  // parse phases
  localparam logic [2:0] PhSpace  = 3'd0;  // skipping leading whitespace
  localparam logic [2:0] PhSigned = 3'd1;  // sign seen, number not started
  localparam logic [2:0] PhZero   = 3'd2;  // leading zero seen, x may follow
  localparam logic [2:0] PhXseen  = 3'd3;  // 0x seen, waiting for a hex digit
  localparam logic [2:0] PhDigits = 3'd4;  // inside the digit run
  localparam logic [2:0] PhDone   = 3'd5;  // conversion stopped, wait for last

  localparam logic [IndexBits-1:0] PosMax = '1;
  localparam logic [ValueBits-1:0] Half   = {1'b1, {(ValueBits-1){1'b0}}};

  // configuration registers
  logic [BaseBits-1:0] number_base_q;
  logic                signed_result_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      number_base_q   <= '0;
      signed_result_q <= 1'b1;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgNumberBase:   number_base_q   <= cfg_data_i[BaseBits-1:0];
        CfgSignedResult: signed_result_q <= cfg_data_i[0];
        default: ;  // writes to unknown indexes are dropped
      endcase
    end
  end

  // input register
  logic     in_valid_q;
  in_word_t in_word_q;
  logic     fire;

  // the parse step runs when a character is held and, if it closes a string,
  // the result register is free or being drained this cycle
  assign fire       = in_valid_q && (!in_word_q.last || !out_valid_o || out_ready_i);
  assign in_ready_o = !in_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_word_q <= in_word_i;
    end
  end

  // per-string parser state
  logic [2:0]           phase_q, phase_d;
  logic [BaseBits-1:0]  base_q, base_d;
  logic [ValueBits-1:0] acc_q, acc_d;
  logic                 ovf_q, ovf_d;
  logic                 neg_q, neg_d;
  logic                 any_q, any_d;
  logic [IndexBits-1:0] pos_q, pos_d;
  logic [IndexBits-1:0] endpos_q, endpos_d;

  // shared digit step: acc * base + digit, with overflow check
  logic                    take_en;
  logic [BaseBits-1:0]     take_base;
  logic [BaseBits-1:0]     take_dig;
  logic                    take_ok;
  logic [ValueBits+BaseBits-1:0] prod;
  logic [ValueBits+BaseBits:0]   sum;
  logic                    sum_ovf;

  logic [7:0]          c;
  logic [BaseBits-1:0] c_dig;
  logic [IndexBits-1:0] pos_after;
  logic                start;
  logic                zero_start;
  logic [BaseBits-1:0] start_base;

  assign c         = in_word_q.char_code;
  assign c_dig     = digit_of(c);
  assign pos_after = (pos_q == PosMax) ? PosMax : pos_q + IndexBits'(1);

  // first character after whitespace and sign: a lone zero in base 0 or 16
  // may open a hex prefix, base 0 otherwise means decimal
  assign zero_start = (c == 8'h30) &&
                      (number_base_q == BaseBits'(0) || number_base_q == BaseBits'(16));
  always_comb begin
    if (zero_start) begin
      start_base = (number_base_q == BaseBits'(0)) ? BaseBits'(8) : BaseBits'(16);
    end else begin
      start_base = (number_base_q == BaseBits'(0)) ? BaseBits'(10) : number_base_q;
    end
  end

  assign prod    = {{BaseBits{1'b0}}, acc_q} * {{ValueBits{1'b0}}, take_base};
  assign sum     = {1'b0, prod} + (ValueBits+BaseBits+1)'(take_dig);
  assign sum_ovf = |sum[ValueBits+BaseBits:ValueBits];
  assign take_ok = (take_base >= BaseBits'(2)) && (take_base <= BaseBits'(36)) &&
                   (take_dig < take_base);

  always_comb begin
    phase_d   = phase_q;
    base_d    = base_q;
    acc_d     = acc_q;
    ovf_d     = ovf_q;
    neg_d     = neg_q;
    any_d     = any_q;
    endpos_d  = endpos_q;
    pos_d     = pos_after;
    start     = 1'b0;
    take_en   = 1'b0;
    take_base = base_q;
    take_dig  = c_dig;

    unique case (phase_q)
      PhSpace: begin
        if (is_blank(c)) begin
          phase_d = PhSpace;
        end else if (c == 8'h2b || c == 8'h2d) begin
          neg_d   = (c == 8'h2d);
          phase_d = PhSigned;
        end else begin
          start = 1'b1;
        end
      end
      PhSigned: start = 1'b1;
      PhZero: begin
        if (c == 8'h78 || c == 8'h58) begin
          phase_d = PhXseen;
        end else begin
          take_en = 1'b1;
        end
      end
      PhXseen: begin
        if (c_dig < BaseBits'(16)) begin
          base_d    = BaseBits'(16);
          take_base = BaseBits'(16);
          take_en   = 1'b1;
        end else begin
          phase_d = PhDone;
        end
      end
      PhDigits: take_en = 1'b1;
      default:  phase_d = PhDone;
    endcase

    if (start) begin
      base_d    = start_base;
      take_base = start_base;
      take_dig  = zero_start ? BaseBits'(0) : c_dig;
      take_en   = 1'b1;
    end

    if (take_en) begin
      if (!take_ok) begin
        phase_d = PhDone;
      end else begin
        if (sum_ovf) begin
          acc_d = '1;
          ovf_d = 1'b1;
        end else begin
          acc_d = sum[ValueBits-1:0];
        end
        any_d    = 1'b1;
        endpos_d = pos_after;
        // a leading zero keeps the prefix check open
        phase_d  = (start && zero_start) ? PhZero : PhDigits;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhSpace;
      base_q   <= '0;
      acc_q    <= '0;
      ovf_q    <= 1'b0;
      neg_q    <= 1'b0;
      any_q    <= 1'b0;
      pos_q    <= '0;
      endpos_q <= '0;
    end else if (fire) begin
      if (in_word_q.last) begin
        // string closed: start over for the next one
        phase_q  <= PhSpace;
        base_q   <= '0;
        acc_q    <= '0;
        ovf_q    <= 1'b0;
        neg_q    <= 1'b0;
        any_q    <= 1'b0;
        pos_q    <= '0;
        endpos_q <= '0;
      end else begin
        phase_q  <= phase_d;
        base_q   <= base_d;
        acc_q    <= acc_d;
        ovf_q    <= ovf_d;
        neg_q    <= neg_d;
        any_q    <= any_d;
        pos_q    <= pos_d;
        endpos_q <= endpos_d;
      end
    end
  end

  // result shaping from the state after this character
  out_word_t            res;
  logic [ValueBits-1:0] acc_neg;

  assign acc_neg = '0 - acc_d;

  always_comb begin
    res = '0;
    if (any_d) begin
      res.converted = 1'b1;
      res.end_index = endpos_d;
      if (signed_result_q) begin
        if (neg_d) begin
          if (ovf_d || acc_d > Half) begin
            res.value       = Half;
            res.range_error = 1'b1;
          end else begin
            res.value = acc_neg;
          end
        end else begin
          if (ovf_d || acc_d > Half - ValueBits'(1)) begin
            res.value       = Half - ValueBits'(1);
            res.range_error = 1'b1;
          end else begin
            res.value = acc_d;
          end
        end
      end else begin
        if (ovf_d) begin
          // sign is ignored on unsigned overflow
          res.value       = '1;
          res.range_error = 1'b1;
        end else begin
          res.value = neg_d ? acc_neg : acc_d;
        end
      end
    end
  end

  // result register
  logic      out_valid_q;
  out_word_t out_word_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire && in_word_q.last) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && in_word_q.last) begin
      out_word_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

`default_nettype wire

// ===== rtl/core/itp_checker.sv =====
// itp_checker: port-level assertions for integer_text_parser, bound to the top level
// depends on itp_pkg for the word structs
`default_nettype none

module itp_checker (
  input wire                            clk_i,
  input wire                            rst_ni,
  input wire                            in_valid_i,
  input wire                            in_ready_o,
  input itp_pkg::in_word_t              in_word_i,
  input wire                            out_valid_o,
  input wire                            out_ready_i,
  input itp_pkg::out_word_t             out_word_o,
  input wire                            cfg_valid_i,
  input wire                            cfg_ready_o,
  input wire [itp_pkg::CfgIdxBits-1:0]  cfg_index_i,
  input wire [itp_pkg::CfgDataBits-1:0] cfg_data_i
);
  import itp_pkg::*;

  localparam logic [ValueBits-1:0] Half = {1'b1, {(ValueBits-1){1'b0}}};

  // a held result word does not change before it is taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_word_o))
    else $error("result word changed while stalled");

  // nothing converted means an all-zero result
  a_no_digit_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_word_o.converted |->
      out_word_o.value == '0 && out_word_o.end_index == '0 && !out_word_o.range_error)
    else $error("unconverted result is not zero");

  // a conversion always consumed at least one character
  a_end_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.converted |-> out_word_o.end_index != '0)
    else $error("converted result with zero end index");

  // a range error always gives a limit value
  a_range_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.range_error |->
      out_word_o.value == Half || out_word_o.value == Half - ValueBits'(1) ||
      out_word_o.value == '1)
    else $error("range error without a limit value");

  // a fresh result follows an accepted character
  a_result_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 2))
    else $error("result word without an accepted character");

endmodule

bind integer_text_parser itp_checker u_itp_checker (.*);

`default_nettype wire

// ===== dv/integer_text_parser_tb.sv =====
// integer_text_parser_tb: self-checking bench for the streaming text-to-integer parser
// feeds character words, writes the base and signedness registers between phases and
// checks every result word against a built-in model or a typed probe; depends on itp_pkg
module integer_text_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import itp_pkg::*;

  localparam int unsigned CycleLimit  = 1_000_000;
  localparam int unsigned RandomChars = 1550;
  localparam int unsigned IdlePct     = 22;
  localparam int unsigned NumProbes   = 25;
  // slack for the result word to trail its last character
  localparam int unsigned DrainCycles = 4;

  localparam logic [ValueBits-1:0] ValueMax = '1;
  localparam logic [ValueBits-1:0] HalfRange = ValueBits'(1) << (ValueBits - 1);
  localparam logic [IndexBits-1:0] IndexMax = '1;
  localparam logic [CfgIdxBits-1:0] FirstUnmapped = CfgSignedResult + 1'b1;

  // characters the parser treats specially
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChCr    = 8'h0d;
  localparam logic [7:0] ChPlus  = 8'h2b;
  localparam logic [7:0] ChMinus = 8'h2d;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChUpA   = 8'h41;
  localparam logic [7:0] ChUpX   = 8'h58;
  localparam logic [7:0] ChUpZ   = 8'h5a;
  localparam logic [7:0] ChLowA  = 8'h61;
  localparam logic [7:0] ChLowX  = 8'h78;
  localparam logic [7:0] ChLowZ  = 8'h7a;

  typedef enum logic [2:0] {
    PhSpace,
    PhSigned,
    PhZero,
    PhPrefix,
    PhDigits,
    PhDone
  } scan_phase_e;

  // one directed string; the typed result is used only where it is obvious
  typedef struct {
    string                text;
    int                   patch_at;    // index of a raw byte patched into the text, -1 none
    logic [7:0]           patch_byte;
    int                   pad;         // leading blanks in front of the text
    logic [BaseBits-1:0]  base;
    logic                 sgn;
    bit                   typed;
    logic [ValueBits-1:0] value;
    logic [IndexBits-1:0] endx;
    logic                 conv;
    logic                 rerr;
  } probe_t;

  logic clk;
  logic rst_n = 1'b0;

  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_word_t              in_word  = '0;
  logic                  out_valid;
  logic                  out_rdy  = 1'b0;
  out_word_t             out_word;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CfgIdxBits-1:0]  cfg_index = '0;
  logic [CfgDataBits-1:0] cfg_data  = '0;

  int unsigned cycle_count = 0;
  int unsigned errors      = 0;
  int unsigned chars_taken = 0;
  int unsigned idle_pct    = IdlePct;

  // register copies as the parser should hold them
  logic [BaseBits-1:0] cfg_base   = '0;
  logic                cfg_signed = 1'b1;

  // parser model state
  scan_phase_e          phase     = PhSpace;
  logic [BaseBits-1:0]  act_base  = '0;
  logic [ValueBits-1:0] acc       = '0;
  logic                 ovf       = 1'b0;
  logic                 neg       = 1'b0;
  logic                 got_digit = 1'b0;
  logic [IndexBits-1:0] pos       = '0;
  logic [IndexBits-1:0] end_pos   = '0;

  in_word_t  char_feed[$];     // words waiting to be sent
  out_word_t results_due[$];   // results predicted, oldest first
  bit        use_typed = 1'b0;
  out_word_t typed_word = '0;

  probe_t probes [NumProbes];

  integer_text_parser i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_ready_i (out_rdy),
    .out_word_o  (out_word),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // ---------------------------------------------------------------------------
  // parser model
  // ---------------------------------------------------------------------------

  function automatic logic is_white(logic [7:0] c);
    return (c == ChSpace) || (c >= ChTab && c <= ChCr);
  endfunction

  // digit weight of a character, NoDigit for anything else
  function automatic logic [BaseBits-1:0] char_digit(logic [7:0] c);
    if (c >= ChZero && c <= ChNine) return BaseBits'(c - ChZero);
    if (c >= ChLowA && c <= ChLowZ) return BaseBits'(c - ChLowA + 8'd10);
    if (c >= ChUpA && c <= ChUpZ) return BaseBits'(c - ChUpA + 8'd10);
    return NoDigit;
  endfunction

  function automatic void clear_scan();
    phase     = PhSpace;
    act_base  = '0;
    acc       = '0;
    ovf       = 1'b0;
    neg       = 1'b0;
    got_digit = 1'b0;
    pos       = '0;
    end_pos   = '0;
  endfunction

  // fold one digit into the accumulator, or stop the conversion
  function automatic void take_digit(logic [BaseBits-1:0] d, logic [IndexBits-1:0] pos_after);
    logic [ValueBits-1:0] limit;
    if (act_base < 2 || act_base > 36 || d >= act_base) begin
      phase = PhDone;
      return;
    end
    limit = (ValueMax - ValueBits'(d)) / ValueBits'(act_base);
    if (acc > limit) begin
      // saturate and remember it
      acc = ValueMax;
      ovf = 1'b1;
    end else begin
      acc = acc * ValueBits'(act_base) + ValueBits'(d);
    end
    got_digit = 1'b1;
    end_pos   = pos_after;
    phase     = PhDigits;
  endfunction

  // first character after blanks and sign; the base register is sampled here
  function automatic void start_number(logic [7:0] c, logic [IndexBits-1:0] pos_after);
    if (c == ChZero && (cfg_base == 0 || cfg_base == 16)) begin
      act_base = (cfg_base == 0) ? BaseBits'(8) : BaseBits'(16);
      take_digit('0, pos_after);
      // a following x may still turn this into a hex prefix
      phase = PhZero;
    end else begin
      act_base = (cfg_base == 0) ? BaseBits'(10) : cfg_base;
      take_digit(char_digit(c), pos_after);
    end
  endfunction

  // step the model by one accepted character; emit is set on the last one
  function automatic void parse_char(in_word_t w, output bit emit, output out_word_t res);
    logic [IndexBits-1:0] pos_after;
    logic [7:0]           c;
    c = w.char_code;
    pos_after = (pos == IndexMax) ? pos : pos + 1'b1;
    case (phase)
      PhSpace: begin
        if (!is_white(c)) begin
          if (c == ChPlus || c == ChMinus) begin
            neg   = (c == ChMinus);
            phase = PhSigned;
          end else begin
            start_number(c, pos_after);
          end
        end
      end
      PhSigned: start_number(c, pos_after);
      PhZero: begin
        if (c == ChLowX || c == ChUpX) phase = PhPrefix;
        else take_digit(char_digit(c), pos_after);
      end
      PhPrefix: begin
        // the prefix counts only if a hex digit follows it
        if (char_digit(c) < 16) begin
          act_base = BaseBits'(16);
          take_digit(char_digit(c), pos_after);
        end else begin
          phase = PhDone;
        end
      end
      PhDigits: take_digit(char_digit(c), pos_after);
      default: phase = PhDone;
    endcase
    pos  = pos_after;
    emit = w.last;
    res  = '0;
    if (!w.last) return;
    if (got_digit) begin
      res.converted = 1'b1;
      res.end_index = end_pos;
      if (cfg_signed) begin
        // clamp to the signed range; the exact minimum is fine
        if (neg) begin
          if (ovf || acc > HalfRange) begin
            res.value       = HalfRange;
            res.range_error = 1'b1;
          end else begin
            res.value = ~acc + 1'b1;
          end
        end else if (ovf || acc > HalfRange - 1'b1) begin
          res.value       = HalfRange - 1'b1;
          res.range_error = 1'b1;
        end else begin
          res.value = acc;
        end
      end else if (ovf) begin
        // unsigned overflow ignores the sign
        res.value       = ValueMax;
        res.range_error = 1'b1;
      end else begin
        res.value = neg ? ~acc + 1'b1 : acc;
      end
    end
    clear_scan();
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic logic [7:0] blank_char();
    int unsigned r;
    r = $urandom_range(0, 5);
    return (r == 5) ? ChSpace : ChTab + 8'(r);
  endfunction

  // magnitudes biased toward the 32-bit and 31-bit boundaries
  function automatic longint unsigned pick_magnitude();
    longint unsigned bounds [5];
    bounds = '{64'h7fff_ffff, 64'h8000_0000, 64'hffff_ffff, 64'h1_0000_0000, 64'h0};
    case ($urandom_range(0, 9))
      0, 1, 2: return longint'($urandom_range(0, 999));
      3, 4:    return {32'h0, $urandom()};
      5, 6, 7: return bounds[$urandom_range(0, 4)] + longint'($urandom_range(0, 4)) - 2;
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  // build one random string for base setting nb and queue its words
  task automatic queue_string(logic [BaseBits-1:0] nb);
    logic [7:0]      txt[$];
    logic [7:0]      digs[$];
    int unsigned     kind;
    int unsigned     radix;
    int unsigned     d;
    longint unsigned mag;
    kind  = $urandom_range(0, 99);
    radix = (nb >= 2 && nb <= 36) ? nb : 10;
    if (kind < 12) begin
      // pure noise
      repeat ($urandom_range(1, 8)) txt.push_back(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(0, 3)) txt.push_back(blank_char());
      case ($urandom_range(0, 3))
        1: txt.push_back(ChPlus);
        2: txt.push_back(ChMinus);
        default: ;
      endcase
      if (kind < 16) begin
        // zero and x, then a random byte that may or may not be a hex digit
        txt.push_back(ChZero);
        txt.push_back($urandom_range(0, 1) ? ChLowX : ChUpX);
        txt.push_back(8'($urandom_range(0, 255)));
      end else begin
        // a blank right after a sign stops the conversion; without a sign it is skipped
        if (kind < 20) txt.push_back(blank_char());
        if (nb == 0) begin
          case ($urandom_range(0, 2))
            0: begin
              txt.push_back(ChZero);
              txt.push_back($urandom_range(0, 1) ? ChLowX : ChUpX);
              radix = 16;
            end
            1: begin
              txt.push_back(ChZero);
              radix = 8;
            end
            default: radix = 10;
          endcase
        end else if (nb == 16 && $urandom_range(0, 1)) begin
          txt.push_back(ChZero);
          txt.push_back($urandom_range(0, 1) ? ChLowX : ChUpX);
        end
        mag = pick_magnitude();
        do begin
          d   = int'(mag % radix);
          mag = mag / radix;
          if (d < 10) digs.push_front(8'(ChZero + d));
          else digs.push_front(8'(($urandom_range(0, 1) ? ChLowA : ChUpA) + d - 10));
        end while (mag != 0);
        foreach (digs[k]) txt.push_back(digs[k]);
      end
      // trailing junk after the number
      if ($urandom_range(0, 9) < 3) begin
        repeat ($urandom_range(1, 3)) txt.push_back(8'($urandom_range(0, 255)));
      end
    end
    foreach (txt[k]) char_feed.push_back('{char_code: txt[k], last: (k == txt.size() - 1)});
  endtask

  // send every queued character word, idling at random between words
  task automatic stream_chars();
    in_word_t  w;
    out_word_t res;
    bit        emit;
    while (char_feed.size() != 0) begin
      w = char_feed.pop_front();
      in_word  <= w;
      in_valid <= 1'b1;
      do @(posedge clk); while (!in_ready);
      parse_char(w, emit, res);
      if (emit) results_due.push_back(use_typed ? typed_word : res);
      chars_taken++;
      if (char_feed.size() == 0 || $urandom_range(0, 99) < idle_pct) begin
        in_valid <= 1'b0;
        do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
      end
    end
  endtask

  // wait for the parser to go quiet, then write both registers
  task automatic write_config(logic [BaseBits-1:0] nb, logic sgn);
    logic [CfgIdxBits-1:0]  idx_q[$];
    logic [CfgDataBits-1:0] dat_q[$];
    while (results_due.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    // now and then hit an index that maps to no register
    if ($urandom_range(0, 3) == 0) begin
      idx_q.push_back(CfgIdxBits'($urandom_range(FirstUnmapped, {CfgIdxBits{1'b1}})));
      dat_q.push_back(CfgDataBits'($urandom_range(0, 255)));
    end
    // unused upper data bits carry random values
    idx_q.push_back(CfgNumberBase);
    dat_q.push_back({2'($urandom_range(0, 3)), nb});
    idx_q.push_back(CfgSignedResult);
    dat_q.push_back({7'($urandom_range(0, 127)), sgn});
    foreach (idx_q[k]) begin
      cfg_index <= idx_q[k];
      cfg_data  <= dat_q[k];
      cfg_valid <= 1'b1;
      do @(posedge clk); while (!cfg_ready);
      if (idx_q[k] == CfgNumberBase) cfg_base = dat_q[k][BaseBits-1:0];
      else if (idx_q[k] == CfgSignedResult) cfg_signed = dat_q[k][0];
    end
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // result side: random stalls and the scoreboard
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    out_rdy <= ($urandom_range(0, 99) >= idle_pct);
  end

  function automatic void check_field(string name, longint unsigned want, longint unsigned got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h got %0h", $realtime, name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    out_word_t want;
    if (rst_n && out_valid && out_rdy) begin
      if (results_due.size() == 0) begin
        $display("%0t: result word with nothing expected, got %h", $realtime, out_word);
        errors++;
      end else begin
        want = results_due.pop_front();
        check_field("value", want.value, out_word.value);
        check_field("end_index", want.end_index, out_word.end_index);
        check_field("converted", want.converted, out_word.converted);
        check_field("range_error", want.range_error, out_word.range_error);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("FAIL integer_text_parser");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin
    int unsigned         phase_no;
    int unsigned         chars_start;
    int                  len;
    logic [7:0]          ch;
    logic [BaseBits-1:0] nb;
    logic                sgn;
    logic [BaseBits-1:0] base_sweep [8];

    // text, patch index, patch byte, pad, base, signed, typed, value, end, converted, error
    probes = '{
      // right after reset: auto base, signed
      '{"0", -1, 8'h00, 0, 6'd0, 1'b1, 1'b1, 32'h0, 16'd1, 1'b1, 1'b0},
      // exact minimum is no error
      '{"   -2147483648", -1, 8'h00, 0, 6'd10, 1'b1, 1'b1, 32'h8000_0000, 16'd14, 1'b1, 1'b0},
      '{"2147483648", -1, 8'h00, 0, 6'd10, 1'b1, 1'b1, 32'h7fff_ffff, 16'd10, 1'b1, 1'b1},
      '{"-2147483649", -1, 8'h00, 0, 6'd10, 1'b1, 1'b1, 32'h8000_0000, 16'd11, 1'b1, 1'b1},
      '{"2147483647", -1, 8'h00, 0, 6'd10, 1'b1, 1'b1, 32'h7fff_ffff, 16'd10, 1'b1, 1'b0},
      // unsigned: top value, overflow, wrapped negative, overflow ignoring the sign
      '{"4294967295", -1, 8'h00, 0, 6'd10, 1'b0, 1'b1, 32'hffff_ffff, 16'd10, 1'b1, 1'b0},
      '{"4294967296", -1, 8'h00, 0, 6'd10, 1'b0, 1'b1, 32'hffff_ffff, 16'd10, 1'b1, 1'b1},
      '{"-1", -1, 8'h00, 0, 6'd10, 1'b0, 1'b1, 32'hffff_ffff, 16'd2, 1'b1, 1'b0},
      '{"-4294967296", -1, 8'h00, 0, 6'd10, 1'b0, 1'b1, 32'hffff_ffff, 16'd11, 1'b1, 1'b1},
      '{"0x1F", -1, 8'h00, 0, 6'd0, 1'b0, 1'b0, 32'h0, 16'd0, 1'b0, 1'b0},
      // dangling prefix: only the zero converts
      '{"0x", -1, 8'h00, 0, 6'd0, 1'b0, 1'b1, 32'h0, 16'd1, 1'b1, 1'b0},
      '{"0XG", -1, 8'h00, 0, 6'd16, 1'b0, 1'b1, 32'h0, 16'd1, 1'b1, 1'b0},
      '{"-0x80000000", -1, 8'h00, 0, 6'd16, 1'b1, 1'b0, 32'h0, 16'd0, 1'b0, 1'b0},
      '{"017", -1, 8'h00, 0, 6'd0, 1'b1, 1'b0, 32'h0, 16'd0, 1'b0, 1'b0},
      '{"089", -1, 8'h00, 0, 6'd0, 1'b1, 1'b0, 32'h0, 16'd0, 1'b0, 1'b0},
      // blank after the sign converts nothing
      '{"- 5", -1, 8'h00, 0, 6'd10, 1'b1, 1'b1, 32'h0, 16'd0, 1'b0, 1'b0},
      '{"\011\012\013\014\015 +zZ9", -1, 8'h00, 0, 6'd36, 1'b1, 1'b0,
        32'h0, 16'd0, 1'b0, 1'b0},
      '{"ZZZZZZZ", -1, 8'h00, 0, 6'd36, 1'b1, 1'b0, 32'h0, 16'd0, 1'b0, 1'b0},
      '{"1010102", -1, 8'h00, 0, 6'd2, 1'b1, 1'b0, 32'h0, 16'd0, 1'b0, 1'b0},
      // invalid bases at both ends
      '{"123", -1, 8'h00, 0, 6'd1, 1'b1, 1'b1, 32'h0, 16'd0, 1'b0, 1'b0},
      '{"123", -1, 8'h00, 0, 6'd63, 1'b1, 1'b1, 32'h0, 16'd0, 1'b0, 1'b0},
      // nul up front, high byte after digits
      '{"x5", 0, 8'h00, 0, 6'd10, 1'b1, 1'b1, 32'h0, 16'd0, 1'b0, 1'b0},
      '{"42x", 2, 8'hff, 0, 6'd10, 1'b1, 1'b0, 32'h0, 16'd0, 1'b0, 1'b0},
      '{"+", -1, 8'h00, 0, 6'd10, 1'b1, 1'b1, 32'h0, 16'd0, 1'b0, 1'b0},
      // leading blanks count toward the end index
      '{"7", -1, 8'h00, 40, 6'd10, 1'b1, 1'b1, 32'h7, 16'd41, 1'b1, 1'b0}
    };
    base_sweep = '{6'd0, 6'd2, 6'd36, 6'd63, 6'd16, 6'd1, 6'd10, 6'd8};

    clear_scan();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed strings
    foreach (probes[r]) begin
      if (probes[r].base != cfg_base || probes[r].sgn != cfg_signed) begin
        write_config(probes[r].base, probes[r].sgn);
      end
      use_typed  = probes[r].typed;
      typed_word = '{value: probes[r].value, end_index: probes[r].endx,
                     converted: probes[r].conv, range_error: probes[r].rerr};
      repeat (probes[r].pad) char_feed.push_back('{char_code: ChSpace, last: 1'b0});
      len = probes[r].text.len();
      for (int i = 0; i < len; i++) begin
        ch = (i == probes[r].patch_at) ? probes[r].patch_byte : probes[r].text[i];
        char_feed.push_back('{char_code: ch, last: (i == len - 1)});
      end
      stream_chars();
    end
    use_typed = 1'b0;

    // random phases, each under its own register setting
    phase_no    = 0;
    chars_start = chars_taken;
    while (chars_taken - chars_start < RandomChars) begin
      if (phase_no < 8) begin
        nb = base_sweep[phase_no];
      end else begin
        case ($urandom_range(0, 9))
          0, 1:    nb = '0;
          8:       nb = BaseBits'(1);
          9:       nb = BaseBits'($urandom_range(37, 63));
          default: nb = BaseBits'($urandom_range(2, 36));
        endcase
      end
      sgn = (phase_no < 8) ? phase_no[0] : 1'($urandom_range(0, 1));
      write_config(nb, sgn);
      // a stretch of back-to-back traffic on both sides
      idle_pct = (phase_no == 3 || phase_no == 4) ? 0 : IdlePct;
      repeat (15) queue_string(nb);
      stream_chars();
      phase_no++;
    end
    idle_pct = IdlePct;

    while (results_due.size() != 0) @(posedge clk);
    repeat (DrainCycles * 2) @(posedge clk);
    if (errors == 0) begin
      $display("PASS integer_text_parser");
    end else begin
      $display("FAIL integer_text_parser");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/itp_pkg.sv
rtl/core/integer_text_parser.sv
rtl/core/itp_checker.sv
dv/integer_text_parser_tb.sv
